@@ rtl/qvp_pkg.sv @@
// ----------------------------------------------------------------------------
// qvp_pkg
// types and constants shared by the quad virtual point block
// ----------------------------------------------------------------------------
package qvp_pkg;

   localparam int COORD_W   = 32;
   localparam int FRAC_BITS = 16;
   localparam int TAG_W     = 16;
   localparam int FIT_BITS  = 31;
   localparam int MUL_W     = 32;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int EDGE_W    = COORD_W + 1;
   localparam int TOT_W     = COORD_W + 3;
   localparam int ROOT_W    = PROD_W / 2;
   localparam int QUO_W     = FRAC_BITS + 1;
   localparam int DVD_W     = ROOT_W + FRAC_BITS;

   localparam logic signed [TOT_W-1:0] SAT_HI =
      signed'(TOT_W'((65'd1 << (COORD_W - 1)) - 65'd1));
   localparam logic signed [TOT_W-1:0] SAT_LO = -SAT_HI - TOT_W'(1);

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type        point_x;
      coord_type        point_y;
      coord_type        point_z;
      logic [TAG_W-1:0] tag_id;
   } req_type;

   typedef struct packed {
      coord_type        virt_x;
      coord_type        virt_y;
      coord_type        virt_z;
      logic [TAG_W-1:0] out_tag;
   } rsp_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } corner_type;

   function automatic coord_type pick(input corner_type c, input int k);
      coord_type v;
      v = (k == 0) ? c.x : ((k == 1) ? c.y : c.z);
      return v;
   endfunction

endpackage

@@ rtl/qvp_mul.sv @@
// ----------------------------------------------------------------------------
// qvp_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module qvp_mul import qvp_pkg::*; (
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op_a) * PROD_W'(op_b);
   end

   assign prod = prod_ff;

endmodule

@@ rtl/qvp_sqrt.sv @@
// ----------------------------------------------------------------------------
// qvp_sqrt
// bit-serial integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module qvp_sqrt import qvp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [PROD_W-1:0] rad_ff;
   logic [ROOT_W+1:0] rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              done_ff;
   logic [ROOT_W+3:0] rem_t;
   logic [ROOT_W+3:0] trial;

   assign rem_t = {rem_ff, rad_ff[PROD_W-1 -: 2]};
   assign trial = {2'b00, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CNT_W'(ROOT_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cnt_ff != '0) begin
         rad_ff <= rad_ff << 2;
         if (rem_t >= trial) begin
            rem_ff  <= (ROOT_W + 2)'(rem_t - trial);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= (ROOT_W + 2)'(rem_t);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ rtl/qvp_div.sv @@
// ----------------------------------------------------------------------------
// qvp_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module qvp_div import qvp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DVD_W-1:0]  dividend,
   input  logic [ROOT_W-1:0] divisor,
   output logic              done,
   output logic [QUO_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [ROOT_W-1:0] rem_ff;
   logic [QUO_W-1:0]  low_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              done_ff;
   logic [ROOT_W:0]   rem_t;

   assign rem_t = {rem_ff, low_ff[QUO_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CNT_W'(QUO_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= ROOT_W'(dividend[DVD_W-1:QUO_W]);
         low_ff <= dividend[QUO_W-1:0];
         quo_ff <= '0;
      end else if (cnt_ff != '0) begin
         low_ff <= low_ff << 1;
         if (rem_t >= {1'b0, divisor}) begin
            rem_ff <= ROOT_W'(rem_t - {1'b0, divisor});
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_ff <= ROOT_W'(rem_t);
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b0};
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/quad_virtual_point.sv @@
// ----------------------------------------------------------------------------
// quad_virtual_point
// virtual point of a quad tag: corner centroid plus mean unit normal
//
// channel   ports                          dir  beat
// request   start, busy, req_data          in   start && !busy
// response  rsp_valid, rsp_data            out  one-cycle strobe
//
// corners one to three of a group are only stored; busy stays low
// the fourth corner keeps busy high while each corner is processed in turn:
// edges, operand fit, cross products and their squares, and with a nonzero
// normal also a square root and three divides; a final state then responds
// synchronous reset clears the sequencer and the corner count
// the response cannot be stalled; it is shown for exactly one cycle
// ----------------------------------------------------------------------------
module quad_virtual_point import qvp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RDP  = 4'd1;
   localparam logic [3:0] S_RDA  = 4'd2;
   localparam logic [3:0] S_RDB  = 4'd3;
   localparam logic [3:0] S_RDC  = 4'd4;
   localparam logic [3:0] S_EDGE = 4'd5;
   localparam logic [3:0] S_FITE = 4'd6;
   localparam logic [3:0] S_MUL  = 4'd7;
   localparam logic [3:0] S_CVT  = 4'd8;
   localparam logic [3:0] S_FITC = 4'd9;
   localparam logic [3:0] S_SQR  = 4'd10;
   localparam logic [3:0] S_SQGO = 4'd11;
   localparam logic [3:0] S_SQWT = 4'd12;
   localparam logic [3:0] S_DVGO = 4'd13;
   localparam logic [3:0] S_DVWT = 4'd14;
   localparam logic [3:0] S_FIN  = 4'd15;

   logic [3:0]               state_ff, state_in;
   logic [1:0]               count_ff, count_in;
   logic [TAG_W-1:0]         tag_ff, tag_in;
   logic [1:0]               ci_ff, ci_in;
   logic [2:0]               step_ff, step_in;
   corner_type               pi_ff, pi_in, pn1_ff, pn1_in, pn3_ff, pn3_in;
   logic signed [TOT_W-1:0]  tot_ff [3];
   logic signed [TOT_W-1:0]  tot_in [3];
   logic                     as_ff [3];
   logic                     as_in [3];
   logic                     bs_ff [3];
   logic                     bs_in [3];
   logic [EDGE_W-1:0]        am_ff [3];
   logic [EDGE_W-1:0]        am_in [3];
   logic [EDGE_W-1:0]        bm_ff [3];
   logic [EDGE_W-1:0]        bm_in [3];
   logic signed [PROD_W-1:0] c_ff [3];
   logic signed [PROD_W-1:0] c_in [3];
   logic                     cs_ff [3];
   logic                     cs_in [3];
   logic [PROD_W-1:0]        cm_ff [3];
   logic [PROD_W-1:0]        cm_in [3];
   logic [PROD_W-1:0]        n2_ff, n2_in;
   logic [ROOT_W-1:0]        norm_ff, norm_in;
   rsp_type                  rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   corner_type               mem [4];
   corner_type               rd_ff;
   logic [1:0]               rd_addr;
   logic                     accept;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;
   logic                     sq_start, sq_done, dv_start, dv_done;
   logic [ROOT_W-1:0]        sq_root;
   logic [QUO_W-1:0]         dv_quo;
   logic [DVD_W-1:0]         dv_dividend;
   logic [1:0]               kk;

   function automatic logic signed [MUL_W-1:0] smag(input logic s,
                                                    input logic [PROD_W-1:0] m);
      logic signed [MUL_W-1:0] v;
      v = signed'(m[MUL_W-1:0]);
      return s ? -v : v;
   endfunction

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);
   assign kk     = step_ff[1:0];

   // corner store
   always_comb begin
      unique case (state_ff)
         S_RDA:   rd_addr = ci_ff + 2'd1;
         S_RDB:   rd_addr = ci_ff + 2'd3;
         default: rd_addr = ci_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem[count_ff] <= '{x: req_data.point_x, y: req_data.point_y,
                            z: req_data.point_z};
      end
      rd_ff <= mem[rd_addr];
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_SQR) begin
         unique case (step_ff)
            3'd0: begin
               mul_a = smag(1'b0, cm_ff[0]);
               mul_b = smag(1'b0, cm_ff[0]);
            end
            3'd1: begin
               mul_a = smag(1'b0, cm_ff[1]);
               mul_b = smag(1'b0, cm_ff[1]);
            end
            3'd2: begin
               mul_a = smag(1'b0, cm_ff[2]);
               mul_b = smag(1'b0, cm_ff[2]);
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end else begin
         unique case (step_ff)
            3'd0: begin
               mul_a = smag(as_ff[1], PROD_W'(am_ff[1]));
               mul_b = smag(bs_ff[2], PROD_W'(bm_ff[2]));
            end
            3'd1: begin
               mul_a = smag(as_ff[2], PROD_W'(am_ff[2]));
               mul_b = smag(bs_ff[1], PROD_W'(bm_ff[1]));
            end
            3'd2: begin
               mul_a = smag(as_ff[2], PROD_W'(am_ff[2]));
               mul_b = smag(bs_ff[0], PROD_W'(bm_ff[0]));
            end
            3'd3: begin
               mul_a = smag(as_ff[0], PROD_W'(am_ff[0]));
               mul_b = smag(bs_ff[2], PROD_W'(bm_ff[2]));
            end
            3'd4: begin
               mul_a = smag(as_ff[0], PROD_W'(am_ff[0]));
               mul_b = smag(bs_ff[1], PROD_W'(bm_ff[1]));
            end
            3'd5: begin
               mul_a = smag(as_ff[1], PROD_W'(am_ff[1]));
               mul_b = smag(bs_ff[0], PROD_W'(bm_ff[0]));
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
   end

   qvp_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   qvp_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (n2_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   always_comb begin
      if (kk == 2'd0) begin
         dv_dividend = DVD_W'(cm_ff[0]) << FRAC_BITS;
      end else if (kk == 2'd1) begin
         dv_dividend = DVD_W'(cm_ff[1]) << FRAC_BITS;
      end else begin
         dv_dividend = DVD_W'(cm_ff[2]) << FRAC_BITS;
      end
      dv_dividend = dv_dividend + DVD_W'(norm_ff >> 1);
   end

   qvp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start),
      .dividend (dv_dividend),
      .divisor  (norm_ff),
      .done     (dv_done),
      .quotient (dv_quo)
   );

   // sequencer
   always_comb begin
      logic signed [EDGE_W-1:0]  da, db;
      logic                      fa, fb, fc, nxt;
      logic [2:0]                idx;
      logic [PROD_W-1:0]         n2_next;
      logic signed [TOT_W-1:0]   u, t, q;
      logic signed [TOT_W-1:0]   sat [3];

      state_in     = state_ff;
      count_in     = count_ff;
      tag_in       = tag_ff;
      ci_in        = ci_ff;
      step_in      = step_ff;
      pi_in        = pi_ff;
      pn1_in       = pn1_ff;
      pn3_in       = pn3_ff;
      tot_in       = tot_ff;
      as_in        = as_ff;
      am_in        = am_ff;
      bs_in        = bs_ff;
      bm_in        = bm_ff;
      c_in         = c_ff;
      cs_in        = cs_ff;
      cm_in        = cm_ff;
      n2_in        = n2_ff;
      norm_in      = norm_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      sq_start     = 1'b0;
      dv_start     = 1'b0;
      nxt          = 1'b0;
      idx          = step_ff - 3'd1;
      n2_next      = n2_ff;
      u            = '0;
      t            = '0;
      q            = '0;
      da           = '0;
      db           = '0;
      fa           = 1'b0;
      fb           = 1'b0;
      fc           = 1'b0;
      for (int k = 0; k < 3; k++) begin
         sat[k] = '0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               count_in = count_ff + 2'd1;
               if (count_ff == 2'd0) begin
                  tag_in = req_data.tag_id;
               end
               if (count_ff == 2'd3) begin
                  state_in = S_RDP;
                  ci_in    = 2'd0;
                  for (int k = 0; k < 3; k++) begin
                     tot_in[k] = '0;
                  end
               end
            end
         end
         S_RDP: state_in = S_RDA;
         S_RDA: begin
            pi_in = rd_ff;
            for (int k = 0; k < 3; k++) begin
               tot_in[k] = tot_ff[k] + TOT_W'(pick(rd_ff, k));
            end
            state_in = S_RDB;
         end
         S_RDB: begin
            pn1_in   = rd_ff;
            state_in = S_RDC;
         end
         S_RDC: begin
            pn3_in   = rd_ff;
            state_in = S_EDGE;
         end
         S_EDGE: begin
            for (int k = 0; k < 3; k++) begin
               da = EDGE_W'(pick(pn1_ff, k)) - EDGE_W'(pick(pi_ff, k));
               db = EDGE_W'(pick(pn3_ff, k)) - EDGE_W'(pick(pi_ff, k));
               as_in[k] = da[EDGE_W-1];
               bs_in[k] = db[EDGE_W-1];
               am_in[k] = da[EDGE_W-1] ? EDGE_W'(-da) : EDGE_W'(da);
               bm_in[k] = db[EDGE_W-1] ? EDGE_W'(-db) : EDGE_W'(db);
            end
            state_in = S_FITE;
         end
         S_FITE: begin
            fa = 1'b0;
            fb = 1'b0;
            for (int k = 0; k < 3; k++) begin
               if ((am_ff[k] >> FIT_BITS) != '0) fa = 1'b1;
               if ((bm_ff[k] >> FIT_BITS) != '0) fb = 1'b1;
            end
            for (int k = 0; k < 3; k++) begin
               if (fa) am_in[k] = am_ff[k] >> 1;
               if (fb) bm_in[k] = bm_ff[k] >> 1;
            end
            if (!fa && !fb) begin
               state_in = S_MUL;
               step_in  = 3'd0;
            end
         end
         S_MUL: begin
            if (step_ff != 3'd0) begin
               if (idx[0] == 1'b0) begin
                  c_in[idx[2:1]] = prod;
               end else begin
                  c_in[idx[2:1]] = c_ff[idx[2:1]] - prod;
               end
            end
            if (step_ff == 3'd6) begin
               state_in = S_CVT;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_CVT: begin
            for (int k = 0; k < 3; k++) begin
               cs_in[k] = c_ff[k][PROD_W-1];
               cm_in[k] = c_ff[k][PROD_W-1] ? PROD_W'(-c_ff[k]) : PROD_W'(c_ff[k]);
            end
            state_in = S_FITC;
         end
         S_FITC: begin
            fc = 1'b0;
            for (int k = 0; k < 3; k++) begin
               if ((cm_ff[k] >> FIT_BITS) != '0) fc = 1'b1;
            end
            if (fc) begin
               for (int k = 0; k < 3; k++) begin
                  cm_in[k] = cm_ff[k] >> 1;
               end
            end else begin
               state_in = S_SQR;
               step_in  = 3'd0;
               n2_in    = '0;
            end
         end
         S_SQR: begin
            if (step_ff != 3'd0) begin
               n2_next = n2_ff + PROD_W'(unsigned'(prod));
            end
            n2_in = n2_next;
            if (step_ff == 3'd3) begin
               if (n2_next == '0) begin
                  nxt = 1'b1;
               end else begin
                  state_in = S_SQGO;
               end
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_SQGO: begin
            sq_start = 1'b1;
            state_in = S_SQWT;
         end
         S_SQWT: begin
            if (sq_done) begin
               norm_in  = sq_root;
               step_in  = 3'd0;
               state_in = S_DVGO;
            end
         end
         S_DVGO: begin
            dv_start = 1'b1;
            state_in = S_DVWT;
         end
         S_DVWT: begin
            if (dv_done) begin
               u = TOT_W'(signed'({1'b0, dv_quo}));
               if (cs_ff[kk]) begin
                  u = -u;
               end
               tot_in[kk] = tot_ff[kk] + u;
               if (step_ff == 3'd2) begin
                  nxt = 1'b1;
               end else begin
                  step_in  = step_ff + 3'd1;
                  state_in = S_DVGO;
               end
            end
         end
         S_FIN: begin
            for (int k = 0; k < 3; k++) begin
               t = tot_ff[k] + TOT_W'(2);
               q = t >>> 2;
               if (q > SAT_HI) begin
                  sat[k] = SAT_HI;
               end else if (q < SAT_LO) begin
                  sat[k] = SAT_LO;
               end else begin
                  sat[k] = q;
               end
            end
            rsp_in.virt_x  = COORD_W'(sat[0]);
            rsp_in.virt_y  = COORD_W'(sat[1]);
            rsp_in.virt_z  = COORD_W'(sat[2]);
            rsp_in.out_tag = tag_ff;
            rsp_valid_in   = 1'b1;
            state_in       = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (nxt) begin
         if (ci_ff == 2'd3) begin
            state_in = S_FIN;
         end else begin
            ci_in    = ci_ff + 2'd1;
            state_in = S_RDP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         tag_ff       <= '0;
         ci_ff        <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tag_ff       <= tag_in;
         ci_ff        <= ci_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pi_ff   <= pi_in;
      pn1_ff  <= pn1_in;
      pn3_ff  <= pn3_in;
      tot_ff  <= tot_in;
      as_ff   <= as_in;
      am_ff   <= am_in;
      bs_ff   <= bs_in;
      bm_ff   <= bm_in;
      c_ff    <= c_in;
      cs_ff   <= cs_in;
      cm_ff   <= cm_in;
      n2_ff   <= n2_in;
      norm_ff <= norm_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_after_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == S_FIN)
      else $error("response without final step");

   a_rsp_group_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_ff == 2'd0)
      else $error("response while a corner group is open");

   a_fourth_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && count_ff == 2'd3) |=> state_ff == S_RDP)
      else $error("fourth corner did not start the normal pass");

   a_div_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DVWT || state_ff == S_DVGO) |-> step_ff <= 3'd2)
      else $error("divide component index out of range");

endmodule
